// ----- hdl/ltd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltd_pkg
// Shared types and constants for the light table with dedup and aging.
// ---------------------------------------------------------------------------
package ltd_pkg;

    localparam int LTD_DEPTH = 64;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;   // prime = 2^40 + 0x1B3
    localparam int          FNV_PRIME_SH = 40;
    localparam int          HASH_BYTES = 12;

    localparam logic [7:0]  GRACE_RST   = 8'd4;
    localparam logic [49:0] MERGE_RST   = 50'd1638400;
    localparam logic [23:0] MINRAD_RST  = 24'd25;
    localparam logic [23:0] DEFRAD_RST  = 24'd6400;
    localparam logic [7:0]  TTL_STATIC  = 8'hFF;

    typedef enum logic [1:0] {
        REQ_DYNAMIC = 2'd0,
        REQ_STATIC  = 2'd1,
        REQ_FRAME   = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_GRACE   = 2'd0,
        CFG_MERGE   = 2'd1,
        CFG_MINRAD  = 2'd2,
        CFG_DEFRAD  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        stat;
        logic        active;
    } t_flags;

    typedef struct packed {
        t_flags      flags;
        logic [7:0]  ttl;
        logic [63:0] key;
        logic [23:0] quad;
        logic [23:0] lin;
        logic [23:0] radius;
        logic [15:0] col_b;
        logic [15:0] col_g;
        logic [15:0] col_r;
        logic [23:0] pz;
        logic [23:0] py;
        logic [23:0] px;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DUMP_RD,
        ST_DUMP_OUT,
        ST_DUMP_EMPTY
    } t_state;

endpackage

// ----- hdl/light_table_dedup_aging.sv -----
`timescale 1ns / 1ps
// An observation runs the byte-serial hash, then a read/square/compare step per
// stored entry, plus a read and a write of the target entry when it merges. Frame
// end runs an aging pass, refilling each removed slot with the last entry, then
// emits every entry; clear only resets the entry count. One item at a time.
// Reset (synchronous, active low) empties the table and loads register
// defaults; the table RAM itself is not cleared.
// ---------------------------------------------------------------------------
// light_table_dedup_aging
// Tracked light table with hash/proximity dedup and frame aging.
// ---------------------------------------------------------------------------
module light_table_dedup_aging #(
    parameter int TABLE_DEPTH = ltd_pkg::LTD_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, col_r, col_g, col_b, radius_in, lin_att_in, qd_att_in
    input  logic [191:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_col_r, out_col_g, out_col_b,
    // out_radius, out_lin_att, out_qd_att, out_hash
    output logic [255:0] m_axis_tdata,
    // entry_valid
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [49:0]  i_cfg_data
);
    import ltd_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;

    logic [7:0]  r_grace;
    logic [49:0] r_merge;
    logic [23:0] r_minrad, r_defrad;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    t_entry        r_obs;
    logic          r_obs_stat;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic          r_near, n_near;
    logic [AW-1:0] r_near_idx, n_near_idx;
    logic [49:0]   r_best, n_best;
    logic [47:0]   r_sq_x, r_sq_y, r_sq_z;
    logic          r_e_static;
    logic [AW-1:0] r_upd_idx, n_upd_idx;

    logic          r_out_valid, n_out_valid;
    logic [255:0]  r_out_data, n_out_data;
    logic          r_out_user, n_out_user;
    logic          r_out_last, n_out_last;

    logic          w_accept;
    logic          w_out_free;
    logic          w_hash_busy;
    logic [63:0]   w_key;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata, w_merged;
    logic [49:0]   w_d2;
    logic [23:0]   w_rad_in;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grace  <= GRACE_RST;
            r_merge  <= MERGE_RST;
            r_minrad <= MINRAD_RST;
            r_defrad <= DEFRAD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRACE:  r_grace  <= i_cfg_data[7:0];
                CFG_MERGE:  r_merge  <= i_cfg_data;
                CFG_MINRAD: r_minrad <= i_cfg_data[23:0];
                CFG_DEFRAD: r_defrad <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    ltd_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_pos_x (s_axis_tdata[23:0]),
        .i_pos_y (s_axis_tdata[47:24]),
        .i_pos_z (s_axis_tdata[71:48]),
        .o_busy  (w_hash_busy),
        .o_key   (w_key)
    );

    ltd_ram #(.W(ENTRY_W), .D(TABLE_DEPTH), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // dynamic lights substitute a default radius when too small
    assign w_rad_in = (s_axis_tuser == REQ_DYNAMIC && s_axis_tdata[143:120] <= r_minrad)
                      ? r_defrad : s_axis_tdata[143:120];

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_obs_stat      <= (s_axis_tuser == REQ_STATIC);
            r_obs.px        <= s_axis_tdata[23:0];
            r_obs.py        <= s_axis_tdata[47:24];
            r_obs.pz        <= s_axis_tdata[71:48];
            r_obs.col_r     <= s_axis_tdata[87:72];
            r_obs.col_g     <= s_axis_tdata[103:88];
            r_obs.col_b     <= s_axis_tdata[119:104];
            r_obs.radius    <= w_rad_in;
            r_obs.lin       <= s_axis_tdata[167:144];
            r_obs.quad      <= s_axis_tdata[191:168];
            r_obs.key       <= '0;
            r_obs.ttl       <= (s_axis_tuser == REQ_STATIC) ? TTL_STATIC : r_grace;
            r_obs.flags.active <= 1'b1;
            r_obs.flags.stat   <= (s_axis_tuser == REQ_STATIC);
        end
    end

    // squared distance per axis, registered after the multipliers
    function automatic logic [47:0] sq(input logic [23:0] a, input logic [23:0] b);
        logic signed [24:0] d;
        logic signed [49:0] p;
        begin
            d  = $signed({a[23], a}) - $signed({b[23], b});
            p  = d * d;
            sq = p[47:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN_MUL) begin
            r_sq_x     <= sq(r_obs.px, w_rdata.px);
            r_sq_y     <= sq(r_obs.py, w_rdata.py);
            r_sq_z     <= sq(r_obs.pz, w_rdata.pz);
            r_e_static <= w_rdata.flags.stat;
        end
    end

    assign w_d2 = {2'd0, r_sq_x} + {2'd0, r_sq_y} + {2'd0, r_sq_z};

    // merge observation into the stored entry
    always_comb begin
        w_merged = w_rdata;
        if (r_obs_stat || !w_rdata.flags.stat) begin
            w_merged.px = r_obs.px;
            w_merged.py = r_obs.py;
            w_merged.pz = r_obs.pz;
        end
        w_merged.col_r  = (r_obs.col_r > w_rdata.col_r) ? r_obs.col_r : w_rdata.col_r;
        w_merged.col_g  = (r_obs.col_g > w_rdata.col_g) ? r_obs.col_g : w_rdata.col_g;
        w_merged.col_b  = (r_obs.col_b > w_rdata.col_b) ? r_obs.col_b : w_rdata.col_b;
        w_merged.radius = (r_obs.radius > w_rdata.radius) ? r_obs.radius : w_rdata.radius;
        w_merged.lin    = r_obs.lin;
        w_merged.quad   = r_obs.quad;
        w_merged.flags.active = 1'b1;
        w_merged.flags.stat   = w_rdata.flags.stat || r_obs_stat;
        w_merged.ttl    = w_merged.flags.stat ? TTL_STATIC : r_grace;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_near     <= n_near;
        r_near_idx <= n_near_idx;
        r_best     <= n_best;
        r_upd_idx  <= n_upd_idx;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_near      = r_near;
        n_near_idx  = r_near_idx;
        n_best      = r_best;
        n_upd_idx   = r_upd_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_i[AW-1:0];
        w_raddr     = r_i[AW-1:0];
        w_wdata     = w_rdata;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                n_i    = '0;
                n_hit  = 1'b0;
                n_near = 1'b0;
                n_best = r_merge;
                if (w_accept) begin
                    unique case (t_req'(s_axis_tuser))
                        REQ_DYNAMIC, REQ_STATIC: n_state = ST_HASH;
                        REQ_FRAME:               n_state = ST_AGE_RD;
                        REQ_CLEAR:               n_count = '0;
                        default: ;
                    endcase
                end
            end
            ST_HASH: begin
                if (!w_hash_busy) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_i >= r_count) begin
                    // scan done: pick the target, else append if there is room
                    if (r_hit) begin
                        n_upd_idx = r_hit_idx;
                        n_state   = ST_UPD_RD;
                    end else if (r_near && !r_obs_stat) begin
                        n_upd_idx = r_near_idx;
                        n_state   = ST_UPD_RD;
                    end else if (r_count < CW'(TABLE_DEPTH)) begin
                        w_we      = 1'b1;
                        w_waddr   = r_count[AW-1:0];
                        w_wdata   = r_obs;
                        w_wdata.key = w_key;
                        n_count   = r_count + 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    w_re    = 1'b1;
                    n_state = ST_SCAN_MUL;
                end
            end
            ST_SCAN_MUL: begin
                if (!r_hit && w_rdata.key == w_key) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_i[AW-1:0];
                end
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (r_e_static && w_d2 < r_best) begin
                    n_best     = w_d2;
                    n_near     = 1'b1;
                    n_near_idx = r_i[AW-1:0];
                end
                n_i     = r_i + 1'b1;
                n_state = ST_SCAN_RD;
            end
            ST_UPD_RD: begin
                w_re    = 1'b1;
                w_raddr = r_upd_idx;
                n_state = ST_UPD_WR;
            end
            ST_UPD_WR: begin
                w_we    = 1'b1;
                w_waddr = r_upd_idx;
                w_wdata = w_merged;
                n_state = ST_IDLE;
            end
            ST_AGE_RD: begin
                if (r_i >= r_count) begin
                    n_i     = '0;
                    n_state = (r_count == '0) ? ST_DUMP_EMPTY : ST_DUMP_RD;
                end else begin
                    w_re    = 1'b1;
                    n_state = ST_AGE_CHK;
                end
            end
            ST_AGE_CHK: begin
                n_state = ST_AGE_RD;
                if (!w_rdata.flags.active && !w_rdata.flags.stat) begin
                    if (w_rdata.ttl <= 8'd1) begin
                        n_count = r_count - 1'b1;
                        n_state = ST_MOVE_RD;
                    end else begin
                        w_we        = 1'b1;
                        w_wdata     = w_rdata;
                        w_wdata.ttl = w_rdata.ttl - 8'd1;
                        n_i         = r_i + 1'b1;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_MOVE_RD: begin
                // pull the last entry into the freed slot
                w_re    = 1'b1;
                w_raddr = r_count[AW-1:0];
                n_state = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
                n_state = ST_AGE_RD;
            end
            ST_DUMP_RD: begin
                w_re    = 1'b1;
                n_state = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b1;
                    n_out_last  = (r_i + 1'b1 == r_count);
                    n_out_data  = {w_rdata.key, w_rdata.quad, w_rdata.lin, w_rdata.radius,
                                   w_rdata.col_b, w_rdata.col_g, w_rdata.col_r,
                                   w_rdata.pz, w_rdata.py, w_rdata.px};
                    w_we        = 1'b1;
                    w_wdata     = w_rdata;
                    if (!w_rdata.flags.stat) begin
                        w_wdata.flags.active = 1'b0;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = (r_i + 1'b1 == r_count) ? ST_IDLE : ST_DUMP_RD;
                end
            end
            ST_DUMP_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_user  = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_data  = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == REQ_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("empty-table result not marked last");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("table write while idle");
`endif
endmodule

// ----- hdl/ltd_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltd_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module ltd_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/ltd_hash.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ltd_hash
// Byte-serial FNV-1a over the quantized position, one byte per cycle.
// ---------------------------------------------------------------------------
module ltd_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_pos_x,
    input  logic [23:0] i_pos_y,
    input  logic [23:0] i_pos_z,
    output logic        o_busy,
    output logic [63:0] o_key
);
    import ltd_pkg::*;

    logic [3:0]  r_cnt;
    logic [95:0] r_bytes;
    logic [63:0] r_h;
    logic [63:0] w_t;
    logic [63:0] w_h_next;
    logic [31:0] w_qx, w_qy, w_qz;

    function automatic logic [31:0] quant(input logic [23:0] p);
        logic signed [24:0] b;
        begin
            b = $signed({p[23], p}) + 25'sd256;
            quant = {{16{b[24]}}, b[24:9]};
        end
    endfunction

    assign w_qx = quant(i_pos_x);
    assign w_qy = quant(i_pos_y);
    assign w_qz = quant(i_pos_z);

    // h * prime = (h << 40) + h * 0x1B3
    assign w_t      = r_h ^ {56'd0, r_bytes[7:0]};
    assign w_h_next = (w_t << FNV_PRIME_SH) + 64'(w_t * {55'd0, FNV_PRIME_LO});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 4'(HASH_BYTES);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bytes <= {w_qz, w_qy, w_qx};
            r_h     <= FNV_BASIS;
        end else if (r_cnt != '0) begin
            r_bytes <= {8'd0, r_bytes[95:8]};
            r_h     <= w_h_next;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_key  = r_h;
endmodule
